// File: src/hls_pkg.sv
// shared constants, types and gain tables for the heater level sequencer
`default_nettype none
package hls_pkg;

  localparam int SAMPLE_WIDTH_DEF = 10;
  localparam int LEVELS           = 8;
  localparam int LEVEL_W          = 3;
  localparam int CFG_IDX_W        = 4;
  localparam int PHASE_W          = 6;
  localparam int HOLD_W           = 8;
  localparam int PREHEAT_LIMIT    = 5;
  localparam int ERR_LIMIT        = 127;
  localparam int ERR_W            = 8;
  localparam int PGAIN_W          = 2;
  localparam int IGAIN_W          = 3;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(LEVELS - 1);
  localparam logic [PGAIN_W-1:0] PGAIN_RST = PGAIN_W'(1);
  localparam logic [IGAIN_W-1:0] IGAIN_RST = IGAIN_W'(1);

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_TICK   = 1'b1
  } action_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]      led_level;
    logic                    error_valid;
    logic signed [ERR_W-1:0] clamped_error;
    logic [PGAIN_W-1:0]      proportional_gain;
    logic [IGAIN_W-1:0]      integral_gain;
    logic [LEVEL_W-1:0]      selected_level;
  } hls_result_t;

  function automatic logic [PGAIN_W-1:0] p_gain_of(input logic [LEVEL_W-1:0] lvl);
    logic [PGAIN_W-1:0] g;
    unique case (lvl)
      3'd0, 3'd1, 3'd2, 3'd3: g = PGAIN_W'(1);
      default:                g = PGAIN_W'(2);
    endcase
    return g;
  endfunction

  function automatic logic [IGAIN_W-1:0] i_gain_of(input logic [LEVEL_W-1:0] lvl);
    logic [IGAIN_W-1:0] g;
    unique case (lvl)
      3'd0, 3'd1, 3'd2: g = IGAIN_W'(1);
      3'd3, 3'd4, 3'd5: g = IGAIN_W'(2);
      default:          g = IGAIN_W'(4);
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

// File: src/hls_cfg.sv
// setpoint register bank, one entry per level, two combinational read ports
`default_nettype none
module hls_cfg #(
  parameter int SAMPLE_WIDTH = hls_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [hls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SAMPLE_WIDTH-1:0]       cfg_wdata,
  input  wire logic [hls_pkg::LEVEL_W-1:0]   rd_a_lvl,
  input  wire logic [hls_pkg::LEVEL_W-1:0]   rd_b_lvl,
  output logic      [SAMPLE_WIDTH-1:0]       rd_a_data,
  output logic      [SAMPLE_WIDTH-1:0]       rd_b_data
);
  import hls_pkg::*;

  logic [SAMPLE_WIDTH-1:0] setpoint_r [LEVELS];
  logic                    idx_in_range;

  // indexes past the last level are dropped
  assign idx_in_range = (cfg_index[CFG_IDX_W-1:LEVEL_W] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LEVELS; k++) begin
        setpoint_r[k] <= '0;
      end
    end else if (cfg_we && idx_in_range) begin
      setpoint_r[cfg_index[LEVEL_W-1:0]] <= cfg_wdata;
    end
  end

  assign rd_a_data = setpoint_r[rd_a_lvl];
  assign rd_b_data = setpoint_r[rd_b_lvl];

endmodule
`default_nettype wire

// File: src/hls_core.sv
// level, preheat, blink and button state with the per-item update logic
`default_nettype none
module hls_core #(
  parameter int SAMPLE_WIDTH = hls_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic                        action,
  input  wire logic [SAMPLE_WIDTH-1:0]     adc_sample,
  input  wire logic                        button_released,
  input  wire logic [SAMPLE_WIDTH-1:0]     sp_work,
  input  wire logic [SAMPLE_WIDTH-1:0]     sp_chosen,
  output logic      [hls_pkg::LEVEL_W-1:0] working_lvl,
  output logic      [hls_pkg::LEVEL_W-1:0] chosen_lvl,
  output hls_pkg::hls_result_t             result
);
  import hls_pkg::*;

  localparam logic signed [SAMPLE_WIDTH:0] PRE_LIM = (SAMPLE_WIDTH+1)'(PREHEAT_LIMIT);
  localparam logic signed [SAMPLE_WIDTH:0] ERR_HI  = (SAMPLE_WIDTH+1)'(ERR_LIMIT);
  localparam logic signed [SAMPLE_WIDTH:0] ERR_LO  = -ERR_HI;

  logic [LEVEL_W-1:0] chosen_r, chosen_nxt;
  logic [LEVEL_W-1:0] working_r, working_nxt;
  logic               preheat_r, preheat_nxt;
  logic               blink_r, blink_nxt;
  logic               pressed_r, pressed_nxt;
  logic [HOLD_W-1:0]  hold_r, hold_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [LEVEL_W-1:0] led_r, led_nxt;
  logic [PGAIN_W-1:0] pgain_r, pgain_nxt;
  logic [IGAIN_W-1:0] igain_r, igain_nxt;

  logic signed [SAMPLE_WIDTH:0] err_old;
  logic signed [SAMPLE_WIDTH:0] err_chosen;
  logic signed [SAMPLE_WIDTH:0] err_new;
  logic signed [ERR_W-1:0]      err_clamped;
  logic                         preheat_end;
  logic                         is_tick;

  assign is_tick    = (action == ACT_TICK);
  assign err_old    = $signed({1'b0, sp_work}) - $signed({1'b0, adc_sample});
  assign err_chosen = $signed({1'b0, sp_chosen}) - $signed({1'b0, adc_sample});
  assign preheat_end = preheat_r && (err_old < PRE_LIM);
  // after preheat ends the error is taken against the chosen level
  assign err_new = preheat_end ? err_chosen : err_old;

  always_comb begin
    if (err_new > ERR_HI) begin
      err_clamped = ERR_W'(ERR_HI);
    end else if (err_new < ERR_LO) begin
      err_clamped = ERR_W'(ERR_LO);
    end else begin
      err_clamped = err_new[ERR_W-1:0];
    end
  end

  always_comb begin
    chosen_nxt  = chosen_r;
    working_nxt = working_r;
    preheat_nxt = preheat_r;
    blink_nxt   = blink_r;
    pressed_nxt = pressed_r;
    hold_nxt    = hold_r;
    phase_nxt   = phase_r;
    led_nxt     = led_r;
    pgain_nxt   = pgain_r;
    igain_nxt   = igain_r;
    if (!is_tick) begin
      if (preheat_end) begin
        working_nxt = chosen_r;
        preheat_nxt = 1'b0;
      end
      if (blink_r && !preheat_nxt && (err_old > 0) && (err_old < PRE_LIM)) begin
        led_nxt   = chosen_r;
        blink_nxt = 1'b0;
      end
    end else begin
      phase_nxt = phase_r + PHASE_W'(1);
      if (blink_r) begin
        if (phase_nxt[PHASE_W-2:0] == '0) begin
          led_nxt = chosen_r;
        end else if (!phase_nxt[PHASE_W-1]) begin
          led_nxt = '0;
        end
      end
      if (pressed_r) begin
        hold_nxt = hold_r + HOLD_W'(1);
        // long hold wraps the counter: power off
        if (hold_nxt == '0) begin
          chosen_nxt  = '0;
          working_nxt = '0;
          led_nxt     = '0;
        end
      end
      if (!button_released && !pressed_r) begin
        pressed_nxt = 1'b1;
        hold_nxt    = '0;
        chosen_nxt  = chosen_r + LEVEL_W'(1);
        led_nxt     = chosen_nxt;
        pgain_nxt   = p_gain_of(chosen_nxt);
        igain_nxt   = i_gain_of(chosen_nxt);
        if (chosen_nxt != '0 && chosen_nxt != LEVEL_MAX) begin
          working_nxt = chosen_nxt + LEVEL_W'(1);
          preheat_nxt = 1'b1;
          blink_nxt   = 1'b1;
        end else begin
          working_nxt = chosen_nxt;
          preheat_nxt = 1'b0;
          blink_nxt   = 1'b0;
        end
      end else if (button_released && pressed_r) begin
        pressed_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chosen_r  <= '0;
      working_r <= '0;
      preheat_r <= 1'b0;
      blink_r   <= 1'b0;
      pressed_r <= 1'b0;
      hold_r    <= '0;
      phase_r   <= '0;
      led_r     <= '0;
      pgain_r   <= PGAIN_RST;
      igain_r   <= IGAIN_RST;
    end else if (step) begin
      chosen_r  <= chosen_nxt;
      working_r <= working_nxt;
      preheat_r <= preheat_nxt;
      blink_r   <= blink_nxt;
      pressed_r <= pressed_nxt;
      hold_r    <= hold_nxt;
      phase_r   <= phase_nxt;
      led_r     <= led_nxt;
      pgain_r   <= pgain_nxt;
      igain_r   <= igain_nxt;
    end
  end

  assign working_lvl = working_r;
  assign chosen_lvl  = chosen_r;

  always_comb begin
    result.led_level         = led_nxt;
    result.error_valid       = !is_tick;
    result.clamped_error     = is_tick ? '0 : err_clamped;
    result.proportional_gain = pgain_nxt;
    result.integral_gain     = igain_nxt;
    result.selected_level    = chosen_nxt;
  end

endmodule
`default_nettype wire

// File: src/heater_level_sequencer_unit.sv
// top level of the heater level sequencer: input register, update logic, result register
`default_nettype none
// Heater level sequencer. Each accepted item is either a temperature sample
// (in_action low) or a mains tick (in_action high) and yields exactly one
// result item. A sample compares the setpoint of the working level with
// in_adc_sample, can end preheat and stop the level blink, and reports the
// error clamped to +/-127 with out_error_valid set. A tick advances the
// 64-tick blink phase and handles the button: a press steps the level modulo
// 8, loads the gains and, unless the new level is 0 or 7, preheats one level
// higher; a hold of 256 ticks powers off. Setpoints are written through
// cfg_we/cfg_index/cfg_wdata; indexes 8 and up are ignored. Throughput is one
// item per clock while the result register is free or being emptied: the item
// is registered, the state update is one shallow pass through the setpoint
// read muxes, one subtract and the clamp, and the result lands in the output
// register, which raises out_valid. A result that waits in the output register
// still lets one more item into an empty input register; with both registers
// full the input waits until the result is taken.
module heater_level_sequencer_unit #(
  parameter int SAMPLE_WIDTH = hls_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [hls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SAMPLE_WIDTH-1:0]       cfg_wdata,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_action,
  input  wire logic [SAMPLE_WIDTH-1:0]       in_adc_sample,
  input  wire logic                          in_button_released,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [hls_pkg::LEVEL_W-1:0]   out_led_level,
  output logic                               out_error_valid,
  output logic signed [hls_pkg::ERR_W-1:0]   out_clamped_error,
  output logic      [hls_pkg::PGAIN_W-1:0]   out_proportional_gain,
  output logic      [hls_pkg::IGAIN_W-1:0]   out_integral_gain,
  output logic      [hls_pkg::LEVEL_W-1:0]   out_selected_level
);
  import hls_pkg::*;

  // input register
  logic                    s1_valid_r, s1_valid_nxt;
  logic                    s1_action_r;
  logic [SAMPLE_WIDTH-1:0] s1_sample_r;
  logic                    s1_released_r;

  // result register
  logic        out_valid_r, out_valid_nxt;
  hls_result_t out_res_r;

  logic               advance;
  logic               in_fire;
  logic [LEVEL_W-1:0] working_lvl;
  logic [LEVEL_W-1:0] chosen_lvl;
  logic [SAMPLE_WIDTH-1:0] sp_work;
  logic [SAMPLE_WIDTH-1:0] sp_chosen;
  hls_result_t        core_res;

  // the item in the input register moves on when the result slot is free
  // or is being emptied this cycle
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r   <= in_action;
      s1_sample_r   <= in_adc_sample;
      s1_released_r <= in_button_released;
    end
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  // setpoint bank: one read at the working level, one at the chosen level
  hls_cfg #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .rd_a_lvl  (working_lvl),
    .rd_b_lvl  (chosen_lvl),
    .rd_a_data (sp_work),
    .rd_b_data (sp_chosen)
  );

  // state and update logic, stepped once per item leaving the input register
  hls_core #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (advance),
    .action          (s1_action_r),
    .adc_sample      (s1_sample_r),
    .button_released (s1_released_r),
    .sp_work         (sp_work),
    .sp_chosen       (sp_chosen),
    .working_lvl     (working_lvl),
    .chosen_lvl      (chosen_lvl),
    .result          (core_res)
  );

  assign out_valid             = out_valid_r;
  assign out_led_level         = out_res_r.led_level;
  assign out_error_valid       = out_res_r.error_valid;
  assign out_clamped_error     = out_res_r.clamped_error;
  assign out_proportional_gain = out_res_r.proportional_gain;
  assign out_integral_gain     = out_res_r.integral_gain;
  assign out_selected_level    = out_res_r.selected_level;

  // tick results carry no error
  a_tick_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.error_valid |-> out_res_r.clamped_error == '0)
    else $error("tick result carries a nonzero error");

  // the clamp never lets the most negative code through
  a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_res_r.clamped_error != ERR_W'(1 << (ERR_W - 1)))
    else $error("clamped error outside +/-127");

  // both gains always come from the same level's table entry
  a_gain_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      (out_res_r.proportional_gain == PGAIN_W'(1) &&
        (out_res_r.integral_gain == IGAIN_W'(1) || out_res_r.integral_gain == IGAIN_W'(2))) ||
      (out_res_r.proportional_gain == PGAIN_W'(2) &&
        (out_res_r.integral_gain == IGAIN_W'(2) || out_res_r.integral_gain == IGAIN_W'(4))))
    else $error("gain pair does not match any level");

  // an item held by a full result register stays in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r)
    else $error("stalled item dropped from input register");

endmodule
`default_nettype wire

// File: sim/level_sequencer_checker.sv
// checker for the heater level sequencer: predicts every result item and compares it
module level_sequencer_checker #(
  parameter int SAMPLE_WIDTH = hls_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [hls_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [SAMPLE_WIDTH-1:0]             cfg_wdata,
  input  wire logic                                in_valid,
  input  wire logic                                in_ready,
  input  wire hls_pkg::action_t                    in_action,
  input  wire logic [SAMPLE_WIDTH-1:0]             in_adc_sample,
  input  wire logic                                in_button_released,
  input  wire logic                                out_valid,
  input  wire logic                                out_ready,
  input  wire logic [hls_pkg::LEVEL_W-1:0]         out_led_level,
  input  wire logic                                out_error_valid,
  input  wire logic signed [hls_pkg::ERR_W-1:0]    out_clamped_error,
  input  wire logic [hls_pkg::PGAIN_W-1:0]         out_proportional_gain,
  input  wire logic [hls_pkg::IGAIN_W-1:0]         out_integral_gain,
  input  wire logic [hls_pkg::LEVEL_W-1:0]         out_selected_level,
  output int                                       mismatches,
  output int                                       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import hls_pkg::*;

  // gains per level, level 0 in the low bits
  localparam logic [PGAIN_W*LEVELS-1:0] KP_BY_LEVEL =
    {2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1};
  localparam logic [IGAIN_W*LEVELS-1:0] KI_BY_LEVEL =
    {3'd4, 3'd4, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1};

  logic [SAMPLE_WIDTH-1:0] setpoint_tbl [LEVELS];
  logic [LEVEL_W-1:0]      chosen_lvl;
  logic [LEVEL_W-1:0]      working_lvl;
  logic [LEVEL_W-1:0]      led_shown;
  logic                    preheating;
  logic                    blinking;
  logic                    button_down;
  logic [HOLD_W-1:0]       held_ticks;
  logic [PHASE_W-1:0]      blink_phase;
  logic [PGAIN_W-1:0]      kp;
  logic [IGAIN_W-1:0]      ki;

  hls_result_t expected_results [$];
  int          results_seen;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at result %0d: %s", results_seen, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  task automatic advance_sequencer(input action_t act, input logic [SAMPLE_WIDTH-1:0] smp,
                                   input logic rel, output hls_result_t res);
    int diff;
    res = '0;
    if (act == ACT_SAMPLE) begin
      diff = int'(setpoint_tbl[working_lvl]) - int'(smp);
      if (preheating && diff < PREHEAT_LIMIT) begin
        working_lvl = chosen_lvl;
        preheating  = 1'b0;
      end
      if (blinking && !preheating && diff > 0 && diff < PREHEAT_LIMIT) begin
        led_shown = chosen_lvl;
        blinking  = 1'b0;
      end
      diff = int'(setpoint_tbl[working_lvl]) - int'(smp);
      if (diff > ERR_LIMIT)
        diff = ERR_LIMIT;
      else if (diff < -ERR_LIMIT)
        diff = -ERR_LIMIT;
      res.error_valid   = 1'b1;
      res.clamped_error = diff[ERR_W-1:0];
    end else begin
      blink_phase = blink_phase + 1'b1;
      if (blinking) begin
        if (blink_phase[PHASE_W-2:0] == '0)
          led_shown = chosen_lvl;
        else if (!blink_phase[PHASE_W-1])
          led_shown = '0;
      end
      if (button_down) begin
        held_ticks = held_ticks + 1'b1;
        if (held_ticks == '0) begin
          chosen_lvl  = '0;
          working_lvl = '0;
          led_shown   = '0;
        end
      end
      if (!rel && !button_down) begin
        button_down = 1'b1;
        held_ticks  = '0;
        chosen_lvl  = chosen_lvl + 1'b1;
        led_shown   = chosen_lvl;
        kp          = KP_BY_LEVEL[chosen_lvl*PGAIN_W +: PGAIN_W];
        ki          = KI_BY_LEVEL[chosen_lvl*IGAIN_W +: IGAIN_W];
        if (chosen_lvl != '0 && chosen_lvl != LEVEL_MAX) begin
          working_lvl = chosen_lvl + 1'b1;
          preheating  = 1'b1;
          blinking    = 1'b1;
        end else begin
          working_lvl = chosen_lvl;
          preheating  = 1'b0;
          blinking    = 1'b0;
        end
      end else if (rel && button_down) begin
        button_down = 1'b0;
      end
    end
    res.led_level         = led_shown;
    res.proportional_gain = kp;
    res.integral_gain     = ki;
    res.selected_level    = chosen_lvl;
  endtask

  always @(posedge clk) begin : watch
    hls_result_t want;
    hls_result_t pred;
    if (!rst_n) begin
      for (int k = 0; k < LEVELS; k++)
        setpoint_tbl[k] = '0;
      chosen_lvl  = '0;
      working_lvl = '0;
      led_shown   = '0;
      preheating  = 1'b0;
      blinking    = 1'b0;
      button_down = 1'b0;
      held_ticks  = '0;
      blink_phase = '0;
      kp          = PGAIN_RST;
      ki          = IGAIN_RST;
      expected_results.delete();
    end else begin
      if (cfg_we && cfg_index < LEVELS)
        setpoint_tbl[cfg_index[LEVEL_W-1:0]] = cfg_wdata;
      // results leave before the new item is queued
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result item with no item waiting");
        end else begin
          want = expected_results.pop_front();
          check_field("led_level", out_led_level, want.led_level);
          check_field("error_valid", out_error_valid, want.error_valid);
          check_field("clamped_error", $signed(out_clamped_error),
                      $signed(want.clamped_error));
          check_field("proportional_gain", out_proportional_gain, want.proportional_gain);
          check_field("integral_gain", out_integral_gain, want.integral_gain);
          check_field("selected_level", out_selected_level, want.selected_level);
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        advance_sequencer(in_action, in_adc_sample, in_button_released, pred);
        expected_results.push_back(pred);
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

// File: sim/tb_top.sv
// testbench top for the heater level sequencer: clock, reset, stimulus and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hls_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam logic [SW-1:0] SAMPLE_FULL = '1;

  // setpoint sets loaded between phases
  typedef enum int {
    SP_DIRECTED,
    SP_RANDOM,
    SP_ALL_ZERO,
    SP_ALL_FULL,
    SP_ALL_SAME,
    SP_ALTERNATE
  } sp_pattern_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SW-1:0]        cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  action_t              in_action = ACT_SAMPLE;
  logic [SW-1:0]        in_adc_sample = '0;
  logic                 in_button_released = 1'b1;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [LEVEL_W-1:0]   out_led_level;
  logic                 out_error_valid;
  logic signed [ERR_W-1:0] out_clamped_error;
  logic [PGAIN_W-1:0]   out_proportional_gain;
  logic [IGAIN_W-1:0]   out_integral_gain;
  logic [LEVEL_W-1:0]   out_selected_level;

  int mismatches;
  int outstanding;

  // stimulus-side bookkeeping, only used to aim samples near a live setpoint
  int             sp_written [LEVELS];
  logic [LEVEL_W-1:0] lvl_guess = '0;
  logic           btn_held_now = 1'b0;
  logic [HOLD_W-1:0] hold_seen = '0;
  int             items_sent = 0;
  bit             calm = 1'b0;

  always #5 clk = ~clk;

  heater_level_sequencer_unit dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_action             (in_action),
    .in_adc_sample         (in_adc_sample),
    .in_button_released    (in_button_released),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_led_level         (out_led_level),
    .out_error_valid       (out_error_valid),
    .out_clamped_error     (out_clamped_error),
    .out_proportional_gain (out_proportional_gain),
    .out_integral_gain     (out_integral_gain),
    .out_selected_level    (out_selected_level)
  );

  level_sequencer_checker seq_chk (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_action             (in_action),
    .in_adc_sample         (in_adc_sample),
    .in_button_released    (in_button_released),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_led_level         (out_led_level),
    .out_error_valid       (out_error_valid),
    .out_clamped_error     (out_clamped_error),
    .out_proportional_gain (out_proportional_gain),
    .out_integral_gain     (out_integral_gain),
    .out_selected_level    (out_selected_level),
    .mismatches            (mismatches),
    .outstanding           (outstanding)
  );

  // result side: ready drops at random with odds of 31 in a hundred, never during the calm window
  always @(posedge clk) begin
    if (!rst_n)
      out_ready <= 1'b0;
    else
      out_ready <= calm || ($urandom_range(0, 99) >= 31);
  end

  // present one item, with random idle cycles ahead of it, and hold it until taken;
  // valid is only lowered when an idle cycle follows
  task automatic offer_item(input action_t act, input logic [SW-1:0] smp, input logic btn);
    while (!calm && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_action          <= act;
    in_adc_sample      <= smp;
    in_button_released <= btn;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    items_sent++;
    calm = (items_sent >= 300 && items_sent < 450);
  endtask

  // mains tick; follows the press/hold/release rules to keep lvl_guess current
  task automatic send_tick(input logic btn);
    offer_item(ACT_TICK, SW'($urandom), btn);
    if (btn_held_now) begin
      hold_seen = hold_seen + 1'b1;
      if (hold_seen == '0)
        lvl_guess = '0;
      if (btn)
        btn_held_now = 1'b0;
    end else if (!btn) begin
      btn_held_now = 1'b1;
      hold_seen    = '0;
      lvl_guess    = lvl_guess + 1'b1;
    end
  endtask

  // temperature sample; the button pin is don't-care here so it gets random values
  task automatic send_sample(input logic [SW-1:0] smp);
    offer_item(ACT_SAMPLE, smp, 1'($urandom));
  endtask

  // sample aimed at the setpoint the block is probably comparing against:
  // mostly small errors around the preheat limit, sometimes around the clamp
  function automatic logic [SW-1:0] near_setpoint();
    int target;
    int off;
    int s;
    case ($urandom_range(0, 6))
      0, 1, 2: target = sp_written[LEVEL_W'(lvl_guess + 1'b1)];
      3, 4:    target = sp_written[lvl_guess];
      5:       return SW'($urandom);
      default: target = sp_written[$urandom_range(0, LEVELS - 1)];
    endcase
    if ($urandom_range(0, 3) == 0) begin
      off = $urandom_range(0, 270);
      off = off - 135;
    end else begin
      off = $urandom_range(0, 12);
      off = off - 6;
    end
    s = target - off;
    if (s < 0)
      s = 0;
    else if (s > int'(SAMPLE_FULL))
      s = int'(SAMPLE_FULL);
    return SW'(s);
  endfunction

  // stop sending and wait until every result item has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do
      @(posedge clk);
    while (outstanding != 0);
  endtask

  // write all sixteen indexes; 8 and up must be ignored by the block
  task automatic write_setpoints(input sp_pattern_t pat);
    logic [SW-1:0] val;
    logic [SW-1:0] same;
    same = SW'($urandom_range(1, int'(SAMPLE_FULL) - 1));
    for (int idx = 0; idx < (1 << CFG_IDX_W); idx++) begin
      if (idx >= LEVELS) begin
        val = SW'($urandom);
      end else begin
        case (pat)
          SP_DIRECTED: begin
            case (idx)
              0:       val = '0;
              1, 7:    val = SAMPLE_FULL;
              default: val = SW'(idx * 100);
            endcase
          end
          SP_ALL_ZERO:  val = '0;
          SP_ALL_FULL:  val = SAMPLE_FULL;
          SP_ALL_SAME:  val = same;
          SP_ALTERNATE: val = idx[0] ? SAMPLE_FULL : '0;
          default:      val = SW'($urandom);
        endcase
        sp_written[idx] = int'(val);
      end
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(idx);
      cfg_wdata <= val;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // one random stretch of activity
  task automatic run_episode();
    int kind;
    int span;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      // press, a short hold with samples mixed in, release
      send_tick(1'b0);
      span = $urandom_range(0, 6);
      repeat (span) begin
        if ($urandom_range(0, 1))
          send_tick(1'b0);
        else
          send_sample(near_setpoint());
      end
      send_tick(1'b1);
    end else if (kind < 70) begin
      repeat ($urandom_range(1, 6))
        send_sample(near_setpoint());
    end else if (kind < 90) begin
      // run of released ticks so the blink phase goes around
      repeat ($urandom_range(1, 40)) begin
        if ($urandom_range(0, 7) == 0)
          send_sample(near_setpoint());
        else
          send_tick(1'b1);
      end
    end else if (kind < 99) begin
      // noise: any item, any button level
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 1))
          send_tick(1'($urandom));
        else
          send_sample(SW'($urandom));
      end
    end else begin
      // hold long enough for power-off
      send_tick(1'b0);
      repeat (258) begin
        send_tick(1'b0);
        if ($urandom_range(0, 9) == 0)
          send_sample(near_setpoint());
      end
      send_tick(1'b1);
    end
  endtask

  initial begin : stimulus
    int phase_end;
    sp_pattern_t pat;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    write_setpoints(SP_DIRECTED);

    // directed: setpoints are 0, full scale, 200..600, full scale
    send_sample('0);                  // zero error at level 0
    send_sample(SAMPLE_FULL);         // clamps low
    send_tick(1'b1);                  // plain tick, nothing blinking
    send_tick(1'b0);                  // press: level 1, preheat toward level 2, blink
    send_tick(1'b1);                  // release
    send_sample(SAMPLE_FULL);         // negative error ends preheat, blink stays
    send_sample('0);                  // clamps high at level 1
    send_sample(SW'(1021));           // error of 2 stops the blink
    send_tick(1'b0);                  // press: level 2, preheat toward level 3
    send_sample(SW'(297));            // error of 3 ends preheat and blink together
    send_tick(1'b1);
    send_tick(1'b0);                  // level 3
    send_tick(1'b1);
    send_sample('0);                  // large positive error, preheat stays on
    send_sample(SAMPLE_FULL);
    repeat (4) begin                  // levels 4 to 7, gains change, level 7 clears flags
      send_tick(1'b0);
      send_tick(1'b1);
    end
    send_tick(1'b0);                  // level wraps from 7 back to 0
    send_tick(1'b1);

    // random phases, each behind a full drain and a new setpoint set
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      case (ph)
        0:       pat = SP_RANDOM;
        1:       pat = SP_ALL_SAME;
        2:       pat = SP_ALL_ZERO;
        3:       pat = SP_ALL_FULL;
        4:       pat = SP_ALTERNATE;
        default: pat = SP_RANDOM;
      endcase
      write_setpoints(pat);
      phase_end = items_sent + 75;
      // make sure at least one hold reaches power-off
      if (ph == 1) begin
        send_tick(1'b1);
        send_tick(1'b0);
        repeat (258)
          send_tick(1'b0);
        send_tick(1'b1);
      end
      while (items_sent < phase_end)
        run_episode();
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
